// ----- hdl/scfr_pkg.sv -----
// Package with shared types and constants for the sync checksum frame receiver.
package scfr_pkg;

    // Sequencer states: byte intake, checksum walk, sync scan, frame shift, frame output.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CHECK_END,
        ST_SCAN,
        ST_SCAN_END,
        ST_SHIFT,
        ST_SHIFT_END,
        ST_EMIT
    } t_state;

    // Register map, by register index.
    localparam logic REG_SYNC = 1'b0;

    localparam logic [7:0] SYNC_RESET = 8'hFF;

endpackage

// ----- hdl/scfr_store.sv -----
// Frame buffer memory: one write port and one registered read port.
module scfr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ----- hdl/sync_checksum_frame_receiver_top.sv -----
// Sync byte framing receiver with additive checksum: top level and sequencer.
//
// Usage:
//   Input channel (i_rx_valid / o_rx_stall / i_rx_byte) takes one received byte per
//   word. While hunting, bytes are dropped until one equals the sync register; then
//   FRAME_BYTES bytes are gathered in the frame buffer.
//   A full frame is walked through one shared read port and 8-bit adder: byte 1
//   must equal the low 8 bits of the sum of bytes 2 .. FRAME_BYTES-1.
//   A passing frame is sent on the output channel (o_frame_valid / i_frame_stall)
//   as FRAME_BYTES words with index and last flag; each word waits on the
//   registered read before the next read is issued.
//   A failing frame is scanned for the next sync byte and shifted down, or
//   dropped if none is found. o_rx_stall is high for the whole walk, scan, shift
//   and output of a frame.
//   When the receiver stalls, the output word holds and the read sequencer waits.
//   Reset (synchronous, i_rst_n low) returns to hunting, empties the output and
//   loads the sync register with 0xFF. The buffer itself is not cleared.
//   The sync register sits at APB byte address 0 and may be written while idle.
module sync_checksum_frame_receiver_top #(
    parameter int FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // receive channel
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // frame channel
    output logic        o_frame_valid,
    input  logic        i_frame_stall,
    output logic [7:0]  o_frame_byte,
    output logic [5:0]  o_byte_index,
    output logic        o_last_byte,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int FW = $clog2(FRAME_BYTES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);
    localparam logic [FW-1:0] FULL      = FW'(FRAME_BYTES);

    scfr_pkg::t_state r_state, n_state;
    scfr_pkg::t_state r_rkind;

    logic [FW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_off, n_off;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_ref, n_ref;
    logic [7:0]    r_sync;
    logic          r_rvalid;
    logic [AW-1:0] r_ridx;

    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;

    logic          rx_accept;
    logic          rx_take;
    logic [FW-1:0] fill_inc;
    logic          use_chk;
    logic          use_scan;
    logic          use_shift;
    logic          use_emit;
    logic          sync_hit;
    logic [7:0]    sum_final;
    logic          chk_pass;
    logic          emit_go;

    // ---------------------------------------------------------------------
    // Configuration port: a single sync register, writes need no wait.
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == scfr_pkg::REG_SYNC) ? {24'd0, r_sync} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= scfr_pkg::SYNC_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == scfr_pkg::REG_SYNC) begin
            r_sync <= pwdata[7:0];
        end
    end

    // ---------------------------------------------------------------------
    // Frame buffer
    // ---------------------------------------------------------------------
    scfr_store #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------------
    // Qualifiers for returning read data: each read is tagged with the
    // phase that issued it, so stale data from an abandoned phase drops out.
    // ---------------------------------------------------------------------
    assign rx_accept = i_rx_valid && !o_rx_stall;
    assign rx_take   = rx_accept && ((r_fill != '0) || (i_rx_byte == r_sync));
    assign fill_inc  = r_fill + 1'b1;

    assign use_chk   = r_rvalid && (r_rkind == scfr_pkg::ST_CHECK)
                       && (r_state == scfr_pkg::ST_CHECK || r_state == scfr_pkg::ST_CHECK_END);
    assign use_scan  = r_rvalid && (r_rkind == scfr_pkg::ST_SCAN)
                       && (r_state == scfr_pkg::ST_SCAN || r_state == scfr_pkg::ST_SCAN_END);
    assign use_shift = r_rvalid && (r_rkind == scfr_pkg::ST_SHIFT)
                       && (r_state == scfr_pkg::ST_SHIFT || r_state == scfr_pkg::ST_SHIFT_END);
    assign use_emit  = r_rvalid && (r_rkind == scfr_pkg::ST_EMIT);

    assign sync_hit  = use_scan && (rd_data == r_sync);
    assign sum_final = r_sum + rd_data;
    assign chk_pass  = (sum_final == r_ref);

    // Issue an output read only when nothing is in flight and the output
    // word will be free by the time the data lands.
    assign emit_go   = !use_emit && (!o_frame_valid || !i_frame_stall);

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scfr_pkg::ST_IDLE: begin
                if (rx_take && r_fill != '0 && fill_inc == FULL) begin
                    n_state = scfr_pkg::ST_CHECK;
                end
            end
            scfr_pkg::ST_CHECK: begin
                if (r_ptr == LAST_ADDR) begin
                    n_state = scfr_pkg::ST_CHECK_END;
                end
            end
            scfr_pkg::ST_CHECK_END: begin
                n_state = chk_pass ? scfr_pkg::ST_EMIT : scfr_pkg::ST_SCAN;
            end
            scfr_pkg::ST_SCAN: begin
                priority if (sync_hit) begin
                    n_state = scfr_pkg::ST_SHIFT;
                end else if (r_ptr == LAST_ADDR) begin
                    n_state = scfr_pkg::ST_SCAN_END;
                end
            end
            scfr_pkg::ST_SCAN_END: begin
                n_state = sync_hit ? scfr_pkg::ST_SHIFT : scfr_pkg::ST_IDLE;
            end
            scfr_pkg::ST_SHIFT: begin
                if (r_ptr == LAST_ADDR) begin
                    n_state = scfr_pkg::ST_SHIFT_END;
                end
            end
            scfr_pkg::ST_SHIFT_END: begin
                n_state = scfr_pkg::ST_IDLE;
            end
            scfr_pkg::ST_EMIT: begin
                if (emit_go && r_ptr == LAST_ADDR) begin
                    n_state = scfr_pkg::ST_IDLE;
                end
            end
            default: n_state = scfr_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath control and next values
    // ---------------------------------------------------------------------
    always_comb begin
        o_rx_stall = 1'b1;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = i_rx_byte;
        n_fill     = r_fill;
        n_ptr      = r_ptr;
        n_off      = r_off;
        n_sum      = r_sum;
        n_ref      = r_ref;

        // Checksum accumulation continues into the end state.
        if (use_chk) begin
            if (r_ridx == AW'(1)) begin
                n_ref = rd_data;
            end else begin
                n_sum = sum_final;
            end
        end

        // Shift writes land in the cycle after their reads.
        if (use_shift) begin
            wr_en   = 1'b1;
            wr_addr = r_ridx - r_off;
            wr_data = rd_data;
        end

        unique case (r_state)
            scfr_pkg::ST_IDLE: begin
                o_rx_stall = 1'b0;
                if (rx_take) begin
                    wr_en   = 1'b1;
                    wr_addr = (r_fill == '0) ? '0 : r_fill[AW-1:0];
                    n_fill  = fill_inc;
                    n_ptr   = AW'(1);
                    n_sum   = '0;
                end
            end
            scfr_pkg::ST_CHECK: begin
                rd_en = 1'b1;
                n_ptr = r_ptr + 1'b1;
            end
            scfr_pkg::ST_CHECK_END: begin
                n_ptr = chk_pass ? '0 : AW'(1);
            end
            scfr_pkg::ST_SCAN: begin
                if (sync_hit) begin
                    n_off = r_ridx;
                    n_ptr = r_ridx;
                end else begin
                    rd_en = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                end
            end
            scfr_pkg::ST_SCAN_END: begin
                if (sync_hit) begin
                    n_off = r_ridx;
                    n_ptr = r_ridx;
                end else begin
                    n_fill = '0;
                end
            end
            scfr_pkg::ST_SHIFT: begin
                rd_en = 1'b1;
                n_ptr = r_ptr + 1'b1;
            end
            scfr_pkg::ST_SHIFT_END: begin
                n_fill = FULL - FW'(r_off);
            end
            scfr_pkg::ST_EMIT: begin
                if (emit_go) begin
                    rd_en = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                    if (r_ptr == LAST_ADDR) begin
                        n_fill = '0;
                    end
                end
            end
            default: begin
                n_fill = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= scfr_pkg::ST_IDLE;
            r_fill   <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_rvalid <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_off <= n_off;
        r_sum <= n_sum;
        r_ref <= n_ref;
        if (rd_en) begin
            r_ridx  <= r_ptr;
            r_rkind <= r_state;
        end
    end

    // Output word: load from the buffer read, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_frame_valid <= 1'b0;
        end else if (use_emit) begin
            o_frame_valid <= 1'b1;
        end else if (!i_frame_stall) begin
            o_frame_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (use_emit) begin
            o_frame_byte <= rd_data;
            o_byte_index <= 6'(r_ridx);
            o_last_byte  <= (r_ridx == LAST_ADDR);
        end
    end

endmodule
